// ===== hdl/sod_pkg.sv =====
`timescale 1ns / 1ps
package sod_pkg;

  localparam int TABLE_SIZE_DEF = 4096;

  // port field widths
  localparam int CMD_W      = 1;
  localparam int SAMPLE_W   = 16;
  localparam int TIDX_W     = 13;
  localparam int TVAL_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // configuration register widths
  localparam int DRIVE_W = 27;
  localparam int BIAS_W  = 19;
  localparam int COEF_W  = 30;
  localparam int LEVEL_W = 26;
  localparam int MIX_W   = 17;

  // channel state
  localparam int NUM_CH = 2;
  localparam int CH_W   = 1;
  localparam int ACC_W  = 32;
  localparam logic [CH_W-1:0] CH_LEFT  = CH_W'(0);
  localparam logic [CH_W-1:0] CH_RIGHT = CH_W'(1);

  // shaper position covers [0, 32) in Q20, so it always fits 25 bits
  localparam int POS_W = 25;
  localparam int V_W   = 26;

  // shared multiplier
  localparam int A_W    = 36;
  localparam int B_W    = 31;
  localparam int PROD_W = A_W + B_W;

  // datapath widths
  localparam int WET_W   = 33;
  localparam int DIFF_W  = 36;
  localparam int MIXED_W = 38;
  localparam int DRY_SH  = 13;
  localparam int DRY_W   = SAMPLE_W + DRY_SH;

  // rounding shift amounts
  localparam int unsigned DRIVE_SH = 15;
  localparam int unsigned COEF_SH  = 30;
  localparam int unsigned LEVEL_SH = 24;
  localparam int unsigned MIX_SH   = 16;
  localparam int unsigned OUT_SH   = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME = 1'b0,
    CMD_TABLE = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_GAIN    = 3'd0,
    CFG_SHAPER_BIAS   = 3'd1,
    CFG_DC_BLOCK_COEF = 3'd2,
    CFG_TONE_COEF     = 3'd3,
    CFG_OUTPUT_LEVEL  = 3'd4,
    CFG_DRY_WET_MIX   = 3'd5
  } cfg_idx_t;

  localparam logic [DRIVE_W-1:0]       DRIVE_GAIN_RST    = 27'd8329135;
  localparam logic signed [BIAS_W-1:0] SHAPER_BIAS_RST   = -19'sd18876;
  localparam logic [COEF_W-1:0]        DC_BLOCK_COEF_RST = 30'd1068373120;
  localparam logic [COEF_W-1:0]        TONE_COEF_RST     = 30'd615180000;
  localparam logic [LEVEL_W-1:0]       OUTPUT_LEVEL_RST  = 26'd10585702;
  localparam logic [MIX_W-1:0]         DRY_WET_MIX_RST   = 17'd65536;

  localparam logic signed [V_W-1:0]    SHAPER_SPAN = V_W'(16 << 20);
  localparam logic signed [PROD_W-1:0] DRIVE_CLIP  = PROD_W'(12 << 20);
  localparam logic signed [B_W-1:0]    HP_PART     = B_W'(322122547);
  localparam logic signed [B_W-1:0]    LP_PART     = B_W'(751619277);
  localparam logic signed [PROD_W-1:0] SAT_MAX     = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_MIN     = PROD_W'(-32768);
  localparam logic signed [PROD_W-1:0] PROD_ONE    = PROD_W'(1);

  typedef struct packed {
    logic signed [ACC_W-1:0] shaped;
    logic signed [ACC_W-1:0] highpass;
    logic signed [ACC_W-1:0] tone;
  } chst_t;

  // arithmetic right shift, rounding half away from zero
  function automatic logic signed [PROD_W-1:0] rnd_shift(
    input logic signed [PROD_W-1:0] v,
    input int unsigned              s
  );
    logic signed [PROD_W-1:0] half;
    half = PROD_ONE <<< (s - 1);
    if (v < 0) half = half - PROD_ONE;
    return (v + half) >>> s;
  endfunction

endpackage

// ===== hdl/sod_table_mem.sv =====
`timescale 1ns / 1ps
module sod_table_mem #(
  parameter int DEPTH  = sod_pkg::TABLE_SIZE_DEF + 1,
  parameter int ADDR_W = $clog2(sod_pkg::TABLE_SIZE_DEF + 1)
) (
  input  logic                            clk,
  input  logic                            we_i,
  input  logic [ADDR_W-1:0]               waddr_i,
  input  logic signed [sod_pkg::ACC_W-1:0] wdata_i,
  input  logic                            re_i,
  input  logic [ADDR_W-1:0]               raddr_i,
  output logic signed [sod_pkg::ACC_W-1:0] rdata_o
);
  import sod_pkg::*;

  logic signed [ACC_W-1:0] mem [DEPTH];
  logic signed [ACC_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== hdl/sod_state_mem.sv =====
`timescale 1ns / 1ps
module sod_state_mem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   we_i,
  input  logic [sod_pkg::CH_W-1:0] waddr_i,
  input  sod_pkg::chst_t         wdata_i,
  input  logic                   re_i,
  input  logic [sod_pkg::CH_W-1:0] raddr_i,
  output sod_pkg::chst_t         rdata_o
);
  import sod_pkg::*;

  chst_t             mem [NUM_CH];
  chst_t             rdata_r;
  logic [NUM_CH-1:0] valid_r;
  logic              rvalid_r;

  // an entry never written since reset reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (we_i) valid_r[waddr_i] <= 1'b1;
      if (re_i) rvalid_r <= valid_r[raddr_i];
    end
  end

  always_ff @(posedge clk) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rvalid_r ? rdata_r : '0;

endmodule

// ===== hdl/sod_mul.sv =====
`timescale 1ns / 1ps
module sod_mul (
  input  logic                             clk,
  input  logic signed [sod_pkg::A_W-1:0]    a_i,
  input  logic signed [sod_pkg::B_W-1:0]    b_i,
  output logic signed [sod_pkg::PROD_W-1:0] prod_o
);
  import sod_pkg::*;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a_i * b_i;
  end

  assign prod_o = prod_r;

endmodule

// ===== hdl/stereo_overdrive_fixed_point.sv =====
// A frame transaction runs both channels and then raises out_valid; in_stall holds off new transactions until idle.
// Each channel runs 16 sequencer steps around the single shared multiplier, left then right.
// A table write transaction produces no result. TABLE_SIZE must be a power of two.
// Reset (rst_n, synchronous, active low): control idle, config registers to defaults,
// filter state reads as zero; shaper table contents are undefined until loaded.
`timescale 1ns / 1ps
module stereo_overdrive_fixed_point #(
  parameter int TABLE_SIZE = sod_pkg::TABLE_SIZE_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [sod_pkg::CMD_W-1:0]             in_command,
  input  logic signed [sod_pkg::SAMPLE_W-1:0]   in_left_sample,
  input  logic signed [sod_pkg::SAMPLE_W-1:0]   in_right_sample,
  input  logic [sod_pkg::TIDX_W-1:0]            in_table_index,
  input  logic signed [sod_pkg::TVAL_W-1:0]     in_table_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sod_pkg::SAMPLE_W-1:0]   out_left_out,
  output logic signed [sod_pkg::SAMPLE_W-1:0]   out_right_out,
  input  logic                                  cfg_we,
  input  logic [sod_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sod_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import sod_pkg::*;

  localparam int TBL_LG  = $clog2(TABLE_SIZE);
  localparam int TBL_AW  = $clog2(TABLE_SIZE + 1);
  localparam int STEP_LG = POS_W - TBL_LG;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_DRIVE  = 18'h00002,
    S_CLIP   = 18'h00004,
    S_ADDR_A = 18'h00008,
    S_ADDR_B = 18'h00010,
    S_INTERP = 18'h00020,
    S_SHAPE  = 18'h00040,
    S_HPASS  = 18'h00080,
    S_TONE   = 18'h00100,
    S_LPASS  = 18'h00200,
    S_MIX    = 18'h00400,
    S_WET    = 18'h00800,
    S_LEVEL  = 18'h01000,
    S_DRYWET = 18'h02000,
    S_BLEND  = 18'h04000,
    S_MIXED  = 18'h08000,
    S_SAT    = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  state_t state_r, state_nxt;
  logic [CH_W-1:0] ch_r;

  // configuration registers
  logic [DRIVE_W-1:0]       drive_gain_r;
  logic signed [BIAS_W-1:0] shaper_bias_r;
  logic [COEF_W-1:0]        dc_coef_r;
  logic [COEF_W-1:0]        tone_coef_r;
  logic [LEVEL_W-1:0]       level_r;
  logic [MIX_W-1:0]         mix_r;

  // datapath registers
  logic signed [SAMPLE_W-1:0] left_r, right_r;
  logic signed [V_W-1:0]      v_r;
  logic [TBL_LG-1:0]          idx_r;
  logic [STEP_LG-1:0]         frac_r;
  logic signed [ACC_W-1:0]    a_r, shaped_r, hp_r, lp_r;
  logic signed [PROD_W-1:0]   acc_r;
  logic signed [WET_W-1:0]    wet_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [MIXED_W-1:0]  mixed_r;
  logic signed [SAMPLE_W-1:0] res_left_r, res_right_r;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;
  logic                       out_valid_r;

  logic in_accept, frame_acc, out_free;

  // memories and multiplier
  logic                    tbl_we, tbl_re;
  logic [TBL_AW-1:0]       tbl_waddr, tbl_raddr;
  logic signed [ACC_W-1:0] tbl_rdata;
  logic                    st_we, st_re;
  logic [CH_W-1:0]         st_raddr;
  chst_t                   st_wdata, st_rd;
  logic signed [A_W-1:0]   mul_a;
  logic signed [B_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;

  // combinational datapath
  logic signed [SAMPLE_W-1:0] x_cur;
  logic signed [DRY_W-1:0]    dry;
  logic signed [PROD_W-1:0]   drv_u, drv_c, q30, shp_sum, hp_sum, lp_sum;
  logic signed [PROD_W-1:0]   wet_full, diff_full, mixed_full, fin;
  logic signed [V_W-1:0]      v_nxt;
  logic [V_W-1:0]             pos;
  logic signed [ACC_W-1:0]    shaped_nxt, hp_nxt, lp_nxt;
  logic signed [SAMPLE_W-1:0] sat_nxt;

  assign in_accept = in_valid && !in_stall;
  assign frame_acc = in_accept && (in_command == CMD_FRAME);
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  // shaper table: loaded by table transactions while idle
  assign tbl_we    = in_accept && (in_command == CMD_TABLE) &&
                     (32'(in_table_index) <= 32'(TABLE_SIZE));
  assign tbl_waddr = TBL_AW'(in_table_index);
  assign tbl_re    = (state_r == S_ADDR_A) || (state_r == S_ADDR_B);
  assign tbl_raddr = (state_r == S_ADDR_B) ? TBL_AW'(idx_r) + TBL_AW'(1)
                                           : TBL_AW'(pos[POS_W-1:STEP_LG]);

  sod_table_mem #(
    .DEPTH (TABLE_SIZE + 1),
    .ADDR_W(TBL_AW)
  ) u_tbl (
    .clk    (clk),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(in_table_value),
    .re_i   (tbl_re),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  // channel state: read at channel start, written back in S_WET;
  // the two accesses to one entry never overlap
  assign st_re    = frame_acc || ((state_r == S_SAT) && (ch_r == CH_LEFT));
  assign st_raddr = frame_acc ? CH_LEFT : CH_RIGHT;
  assign st_we    = (state_r == S_WET);
  assign st_wdata = '{shaped: shaped_r, highpass: hp_r, tone: lp_r};

  sod_state_mem u_st (
    .clk    (clk),
    .rst_n  (rst_n),
    .we_i   (st_we),
    .waddr_i(ch_r),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rd)
  );

  sod_mul u_mul (
    .clk   (clk),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  assign x_cur = (ch_r == CH_RIGHT) ? right_r : left_r;
  assign dry   = {x_cur, {DRY_SH{1'b0}}};

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_DRIVE: begin
        mul_a = A_W'(x_cur);
        mul_b = B_W'(drive_gain_r);
      end
      S_INTERP: begin
        mul_a = A_W'(tbl_rdata) - A_W'(a_r);
        mul_b = B_W'(frac_r);
      end
      S_SHAPE: begin
        mul_a = A_W'(st_rd.highpass);
        mul_b = B_W'(dc_coef_r);
      end
      S_TONE: begin
        mul_a = A_W'(hp_r) - A_W'(st_rd.tone);
        mul_b = B_W'(tone_coef_r);
      end
      S_LPASS: begin
        mul_a = A_W'(hp_r);
        mul_b = HP_PART;
      end
      S_MIX: begin
        mul_a = A_W'(lp_r);
        mul_b = LP_PART;
      end
      S_LEVEL: begin
        mul_a = A_W'(wet_r);
        mul_b = B_W'(level_r);
      end
      S_BLEND: begin
        mul_a = diff_r;
        mul_b = B_W'(mix_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    drv_u = rnd_shift(prod, DRIVE_SH);
    if (drv_u > DRIVE_CLIP) begin
      drv_c = DRIVE_CLIP;
    end else if (drv_u < -DRIVE_CLIP) begin
      drv_c = -DRIVE_CLIP;
    end else begin
      drv_c = drv_u;
    end
    v_nxt = $signed(drv_c[V_W-1:0]) + V_W'(shaper_bias_r);
    pos   = $unsigned(v_r + SHAPER_SPAN);

    shp_sum    = PROD_W'(a_r) + rnd_shift(prod, STEP_LG);
    shaped_nxt = shp_sum[ACC_W-1:0];

    q30    = rnd_shift(prod, COEF_SH);
    hp_sum = PROD_W'(shaped_r) - PROD_W'(st_rd.shaped) + q30;
    hp_nxt = hp_sum[ACC_W-1:0];
    lp_sum = PROD_W'(st_rd.tone) + q30;
    lp_nxt = lp_sum[ACC_W-1:0];

    wet_full   = rnd_shift(acc_r + prod, COEF_SH);
    diff_full  = rnd_shift(prod, LEVEL_SH) - PROD_W'(dry);
    mixed_full = PROD_W'(dry) + rnd_shift(prod, MIX_SH);

    fin = rnd_shift(PROD_W'(mixed_r), OUT_SH);
    if (fin > SAT_MAX) begin
      sat_nxt = SAT_MAX[SAMPLE_W-1:0];
    end else if (fin < SAT_MIN) begin
      sat_nxt = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat_nxt = fin[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (frame_acc) state_nxt = S_DRIVE;
      S_DRIVE:  state_nxt = S_CLIP;
      S_CLIP:   state_nxt = S_ADDR_A;
      S_ADDR_A: state_nxt = S_ADDR_B;
      S_ADDR_B: state_nxt = S_INTERP;
      S_INTERP: state_nxt = S_SHAPE;
      S_SHAPE:  state_nxt = S_HPASS;
      S_HPASS:  state_nxt = S_TONE;
      S_TONE:   state_nxt = S_LPASS;
      S_LPASS:  state_nxt = S_MIX;
      S_MIX:    state_nxt = S_WET;
      S_WET:    state_nxt = S_LEVEL;
      S_LEVEL:  state_nxt = S_DRYWET;
      S_DRYWET: state_nxt = S_BLEND;
      S_BLEND:  state_nxt = S_MIXED;
      S_MIXED:  state_nxt = S_SAT;
      S_SAT:    state_nxt = (ch_r == CH_LEFT) ? S_DRIVE : S_DONE;
      S_DONE:   if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ch_r          <= CH_LEFT;
      out_valid_r   <= 1'b0;
      drive_gain_r  <= DRIVE_GAIN_RST;
      shaper_bias_r <= SHAPER_BIAS_RST;
      dc_coef_r     <= DC_BLOCK_COEF_RST;
      tone_coef_r   <= TONE_COEF_RST;
      level_r       <= OUTPUT_LEVEL_RST;
      mix_r         <= DRY_WET_MIX_RST;
    end else begin
      state_r <= state_nxt;
      if (frame_acc) begin
        ch_r <= CH_LEFT;
      end else if ((state_r == S_SAT) && (ch_r == CH_LEFT)) begin
        ch_r <= CH_RIGHT;
      end
      // hold the result until its transaction completes
      if ((state_r == S_DONE) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_DRIVE_GAIN:    drive_gain_r  <= cfg_data[DRIVE_W-1:0];
          CFG_SHAPER_BIAS:   shaper_bias_r <= cfg_data[BIAS_W-1:0];
          CFG_DC_BLOCK_COEF: dc_coef_r     <= cfg_data[COEF_W-1:0];
          CFG_TONE_COEF:     tone_coef_r   <= cfg_data[COEF_W-1:0];
          CFG_OUTPUT_LEVEL:  level_r       <= cfg_data[LEVEL_W-1:0];
          CFG_DRY_WET_MIX:   mix_r         <= cfg_data[MIX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_acc) begin
      left_r  <= in_left_sample;
      right_r <= in_right_sample;
    end
    if (state_r == S_CLIP) v_r <= v_nxt;
    if (state_r == S_ADDR_A) begin
      idx_r  <= pos[POS_W-1:STEP_LG];
      frac_r <= pos[STEP_LG-1:0];
    end
    if (state_r == S_ADDR_B) a_r <= tbl_rdata;
    if (state_r == S_SHAPE) shaped_r <= shaped_nxt;
    if (state_r == S_HPASS) hp_r <= hp_nxt;
    if (state_r == S_LPASS) lp_r <= lp_nxt;
    if (state_r == S_MIX) acc_r <= prod;
    if (state_r == S_WET) wet_r <= wet_full[WET_W-1:0];
    if (state_r == S_DRYWET) diff_r <= diff_full[DIFF_W-1:0];
    if (state_r == S_MIXED) mixed_r <= mixed_full[MIXED_W-1:0];
    if (state_r == S_SAT) begin
      if (ch_r == CH_LEFT) begin
        res_left_r <= sat_nxt;
      end else begin
        res_right_r <= sat_nxt;
      end
    end
    if ((state_r == S_DONE) && out_free) begin
      out_left_r  <= res_left_r;
      out_right_r <= res_right_r;
    end
  end

  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    frame_acc |=> (state_r == S_DRIVE && ch_r == CH_LEFT))
    else $error("frame transaction did not start the left channel");

  a_ch_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SAT && ch_r == CH_LEFT) |=> (state_r == S_DRIVE && ch_r == CH_RIGHT))
    else $error("right channel did not follow the left channel");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done step");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_valid_r && out_stall) |=> (state_r == S_DONE))
    else $error("pending result overwritten");

endmodule
